/* sv/tlm_pkg.sv */
package tlm_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;
  localparam int DATA_W     = 32;
  localparam int OP_W       = 2;

  localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN           = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load_first;   // append beat to first list
    logic load_second;  // append beat to second list
    logic start;        // begin a run
    logic advance;      // pick one element into the output register
    logic finish;       // final element picked: empty both lists
  } tlm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic any_stored;   // at least one list holds an element
    logic out_busy;     // output register full and not taken this cycle
    logic final_pick;   // element picked now is the last of the run
  } tlm_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_EMIT = 3'b100
  } tlm_state_t;

endpackage

/* sv/two_list_merge_core.sv */
// Channel   Handshake               Payload
// input     in_valid / in_ready     operation, value
// output    out_valid / out_ready   merged_value, last
// config    order_mode_wr_en        order_mode_wr_data
//
// Appends are accepted whenever in_ready is high, which is whenever no run is active.
// A run of N elements first reads both list heads from the two 32-entry
// memories in ST_LOAD, then emits one beat per cycle in ST_EMIT unless
// out_ready stalls the output register, which holds the picked beat.
// Reset (rst, synchronous) empties both lists and sets ascending mode.
// A run with both lists empty finishes in its accept cycle with no beat.
module two_list_merge_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tlm_pkg::OP_W-1:0]          operation,
  input  logic signed [tlm_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tlm_pkg::DATA_W-1:0] merged_value,
  output logic                              last,
  input  logic                              order_mode_wr_en,
  input  logic                              order_mode_wr_data
);
  import tlm_pkg::*;

  tlm_cmd_t  cmd;
  tlm_stat_t stat;

  // Sequencer: decodes input beats and paces the run against the output
  tlm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: list memories, counts, heads, compare and output register
  tlm_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .value              (value),
    .order_mode_wr_en   (order_mode_wr_en),
    .order_mode_wr_data (order_mode_wr_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .merged_value       (merged_value),
    .last               (last)
  );

endmodule

/* sv/tlm_ctrl.sv */
module tlm_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [tlm_pkg::OP_W-1:0] operation,
  input  tlm_pkg::tlm_stat_t       stat,
  output tlm_pkg::tlm_cmd_t        cmd
);
  import tlm_pkg::*;

  tlm_state_t state, state_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next       = state;
    cmd              = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (operation)
            OP_APPEND_FIRST:  cmd.load_first  = 1'b1;
            OP_APPEND_SECOND: cmd.load_second = 1'b1;
            OP_RUN: begin
              if (stat.any_stored) begin
                cmd.start  = 1'b1;
                state_next = ST_LOAD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        // memory read of both heads lands this cycle
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.advance = 1'b1;
          if (stat.final_pick) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/tlm_dp.sv */
module tlm_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  tlm_pkg::tlm_cmd_t                 cmd,
  output tlm_pkg::tlm_stat_t                stat,
  input  logic signed [tlm_pkg::DATA_W-1:0] value,
  input  logic                              order_mode_wr_en,
  input  logic                              order_mode_wr_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tlm_pkg::DATA_W-1:0] merged_value,
  output logic                              last
);
  import tlm_pkg::*;

  logic [DATA_W-1:0] first_mem  [LIST_DEPTH];
  logic [DATA_W-1:0] second_mem [LIST_DEPTH];

  logic [CNT_W-1:0]  first_count, second_count;
  logic [CNT_W-1:0]  first_head, second_head;
  logic [CNT_W-1:0]  first_head_next, second_head_next;
  logic [DATA_W-1:0] first_rdata, second_rdata;
  logic              order_mode;
  logic              turn_first;

  logic              have_first, have_second, take_first;
  logic [SUM_W-1:0]  taken_sum, total_sum;

  assign have_first  = first_head < first_count;
  assign have_second = second_head < second_count;

  always_comb begin
    if (have_first && have_second) begin
      if (order_mode) begin
        take_first = $signed(first_rdata) <= $signed(second_rdata);
      end else begin
        take_first = turn_first;
      end
    end else begin
      take_first = have_first;
    end
  end

  assign taken_sum = SUM_W'(first_head) + SUM_W'(second_head) + SUM_W'(1);
  assign total_sum = SUM_W'(first_count) + SUM_W'(second_count);

  assign stat.any_stored = (first_count != '0) || (second_count != '0);
  assign stat.out_busy   = out_valid && !out_ready;
  assign stat.final_pick = (taken_sum == total_sum);

  // Read address runs one ahead of the pick so the head is always registered
  always_comb begin
    first_head_next  = first_head;
    second_head_next = second_head;
    if (cmd.start || cmd.finish) begin
      first_head_next  = '0;
      second_head_next = '0;
    end else if (cmd.advance) begin
      if (take_first) begin
        first_head_next  = first_head + CNT_W'(1);
      end else begin
        second_head_next = second_head + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    first_rdata  <= first_mem[first_head_next[IDX_W-1:0]];
    second_rdata <= second_mem[second_head_next[IDX_W-1:0]];
    if (cmd.load_first && (first_count < CNT_W'(LIST_DEPTH))) begin
      first_mem[first_count[IDX_W-1:0]] <= value;
    end
    if (cmd.load_second && (second_count < CNT_W'(LIST_DEPTH))) begin
      second_mem[second_count[IDX_W-1:0]] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      second_count <= '0;
      first_head   <= '0;
      second_head  <= '0;
      order_mode   <= 1'b1;
      turn_first   <= 1'b1;
      out_valid    <= 1'b0;
    end else begin
      first_head  <= first_head_next;
      second_head <= second_head_next;
      if (order_mode_wr_en) begin
        order_mode <= order_mode_wr_data;
      end
      if (cmd.finish) begin
        first_count  <= '0;
        second_count <= '0;
      end else begin
        if (cmd.load_first && (first_count < CNT_W'(LIST_DEPTH))) begin
          first_count <= first_count + CNT_W'(1);
        end
        if (cmd.load_second && (second_count < CNT_W'(LIST_DEPTH))) begin
          second_count <= second_count + CNT_W'(1);
        end
      end
      if (cmd.start) begin
        turn_first <= 1'b1;
      end else if (cmd.advance && have_first && have_second) begin
        turn_first <= !turn_first;
      end
      if (cmd.advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      merged_value <= take_first ? first_rdata : second_rdata;
      last         <= stat.final_pick;
    end
  end

endmodule

/* test/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlm_pkg::*;

  // Code that the block treats as a no-op; not part of the package.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

  // Cycles to let pass after the last expected beat, so that an empty run
  // or a run still picking its first element has settled.
  localparam int SETTLE_CYCLES  = 4;
  // Cycles in a row with no beat on either channel before giving up.
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic signed [DATA_W-1:0] merged_value;
    logic                     last;
  } merged_beat_t;

  logic                     clk                = 1'b0;
  logic                     rst                = 1'b1;
  logic                     in_valid           = 1'b0;
  logic                     in_ready;
  logic [OP_W-1:0]          operation          = OP_APPEND_FIRST;
  logic signed [DATA_W-1:0] value              = '0;
  logic                     out_valid;
  logic                     out_ready          = 1'b0;
  logic signed [DATA_W-1:0] merged_value;
  logic                     last;
  logic                     order_mode_wr_en   = 1'b0;
  logic                     order_mode_wr_data = 1'b0;

  // Predictor state: contents of both lists and the current merge order.
  logic signed [DATA_W-1:0] first_list[$];
  logic signed [DATA_W-1:0] second_list[$];
  bit                       ascending_order = 1'b1;
  merged_beat_t             pending_beats[$];

  // Idle percentages for the current phase.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int mismatch_count = 0;
  int beats_sent     = 0;
  int beats_merged   = 0;
  int runs_sent      = 0;
  int full_runs      = 0;
  int quiet_cycles   = 0;

  two_list_merge_core i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .operation          (operation),
    .value              (value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .merged_value       (merged_value),
    .last               (last),
    .order_mode_wr_en   (order_mode_wr_en),
    .order_mode_wr_data (order_mode_wr_data)
  );

  always #1 clk = ~clk;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Merge both lists the way the block does: ascending order picks the
  // smaller head (first list wins ties), alternate order takes turns while
  // both lists still hold elements. Then drain the rest and empty both.
  function automatic void merge_lists();
    int           total;
    int           first_pos;
    int           second_pos;
    bit           first_turn;
    bit           take_first;
    merged_beat_t beat;
    total      = first_list.size() + second_list.size();
    first_pos  = 0;
    second_pos = 0;
    first_turn = 1'b1;
    for (int k = 0; k < total; k++) begin
      if (first_pos < first_list.size() && second_pos < second_list.size()) begin
        if (ascending_order) begin
          take_first = first_list[first_pos] <= second_list[second_pos];
        end else begin
          take_first = first_turn;
          first_turn = !first_turn;
        end
      end else begin
        take_first = first_pos < first_list.size();
      end
      if (take_first) begin
        beat.merged_value = first_list[first_pos];
        first_pos++;
      end else begin
        beat.merged_value = second_list[second_pos];
        second_pos++;
      end
      beat.last = (k == total - 1);
      pending_beats.push_back(beat);
    end
    first_list.delete();
    second_list.delete();
  endfunction

  // Update the predictor with one accepted input beat.
  function automatic void apply_item(input logic [OP_W-1:0] op,
                                     input logic signed [DATA_W-1:0] val);
    case (op)
      OP_APPEND_FIRST: begin
        // drop appends to a full list
        if (first_list.size() < LIST_DEPTH) first_list.push_back(val);
      end
      OP_APPEND_SECOND: begin
        if (second_list.size() < LIST_DEPTH) second_list.push_back(val);
      end
      OP_RUN: begin
        merge_lists();
      end
      default: begin
        // unused operation: no effect
      end
    endcase
  endfunction

  // Compare one accepted output beat with the oldest expected one.
  task automatic check_beat(input logic signed [DATA_W-1:0] got_value,
                            input logic got_last);
    merged_beat_t exp_beat;
    if (pending_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected beat value=%0d last=%0b",
                                got_value, got_last));
    end else begin
      exp_beat = pending_beats.pop_front();
      beats_merged++;
      if (got_value !== exp_beat.merged_value)
        report_mismatch($sformatf("merged_value %0d, expected %0d",
                                  got_value, exp_beat.merged_value));
      if (got_last !== exp_beat.last)
        report_mismatch($sformatf("last %0b, expected %0b (value %0d)",
                                  got_last, exp_beat.last, exp_beat.merged_value));
    end
  endtask

  // Sample both channels at the rising edge: check output beats, feed the
  // predictor with input beats, and watch for a hung block.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (out_valid && out_ready) check_beat(merged_value, last);
      if (in_valid && in_ready) apply_item(operation, value);
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        report_mismatch($sformatf("no beat for %0d cycles, %0d beats outstanding",
                                  WATCHDOG_LIMIT, pending_beats.size()));
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: stall at random per the current phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one input beat; hold valid and payload until accepted.
  task automatic send_item(input logic [OP_W-1:0] op,
                           input logic signed [DATA_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    operation = op;
    value     = val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_UNUSED) beats_sent++;
  endtask

  // Drop valid, wait for every expected beat, then let the block settle.
  task automatic drain_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the order register while the block is idle.
  task automatic set_order_mode(input bit ascending);
    drain_block();
    @(negedge clk);
    order_mode_wr_en   = 1'b1;
    order_mode_wr_data = ascending;
    ascending_order    = ascending;
    @(negedge clk);
    order_mode_wr_en   = 1'b0;
  endtask

  // Mostly full-range values, with ties in a narrow band and the extremes.
  function automatic logic signed [DATA_W-1:0] rand_value();
    logic signed [DATA_W-1:0] pick;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       pick = VALUE_MIN;
          1:       pick = VALUE_MAX;
          2:       pick = '0;
          default: pick = -1;
        endcase
      end
      1, 2:    pick = int'($urandom_range(8)) - 4;
      default: pick = $urandom;
    endcase
    return pick;
  endfunction

  // Load the two lists in random interleave, with optional noise beats,
  // then start a run.
  task automatic load_and_run(input int first_len, input int second_len,
                              input int noise_pct);
    int loaded_first;
    int loaded_second;
    loaded_first  = 0;
    loaded_second = 0;
    while (loaded_first < first_len || loaded_second < second_len) begin
      if ($urandom_range(99) < noise_pct) send_item(OP_UNUSED, rand_value());
      if (loaded_second >= second_len ||
          (loaded_first < first_len && $urandom_range(1) == 0)) begin
        send_item(OP_APPEND_FIRST, rand_value());
        loaded_first++;
      end else begin
        send_item(OP_APPEND_SECOND, rand_value());
        loaded_second++;
      end
    end
    send_item(OP_RUN, rand_value());
    runs_sent++;
  endtask

  // Extreme values, ties, one-sided lists, the empty run and the unused
  // operation, in both merge orders; no idling.
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // empty run right after reset: no beat
    send_item(OP_RUN, VALUE_MAX);
    send_item(OP_UNUSED, -1);
    // ascending order (reset value) with signed extremes and ties
    send_item(OP_APPEND_FIRST, VALUE_MAX);
    send_item(OP_APPEND_FIRST, VALUE_MIN);
    send_item(OP_APPEND_FIRST, -1);
    send_item(OP_APPEND_FIRST, 0);
    send_item(OP_APPEND_SECOND, VALUE_MIN);
    send_item(OP_APPEND_SECOND, VALUE_MAX);
    send_item(OP_APPEND_SECOND, 0);
    send_item(OP_RUN, 0);
    // single element: first beat is also the last
    send_item(OP_APPEND_FIRST, 5);
    send_item(OP_RUN, -1);
    // second list alone
    send_item(OP_APPEND_SECOND, 32'sh5555_5555);
    send_item(OP_APPEND_SECOND, 32'shAAAA_AAAA);
    send_item(OP_RUN, 0);
    // alternate order with the first list longer
    set_order_mode(1'b0);
    send_item(OP_APPEND_FIRST, 1);
    send_item(OP_APPEND_SECOND, 10);
    send_item(OP_APPEND_FIRST, 2);
    send_item(OP_APPEND_FIRST, 3);
    send_item(OP_RUN, 0);
    send_item(OP_UNUSED, 0);
    send_item(OP_RUN, VALUE_MIN);
    runs_sent += 6;
  endtask

  // Overfill the lists so that extra appends are dropped, in both orders.
  task automatic test_full_lists();
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    set_order_mode(1'b1);
    load_and_run(LIST_DEPTH + $urandom_range(1, 4), LIST_DEPTH + $urandom_range(1, 4), 0);
    set_order_mode(1'b0);
    load_and_run(LIST_DEPTH + $urandom_range(1, 4), LIST_DEPTH + $urandom_range(1, 4), 0);
    load_and_run(LIST_DEPTH + $urandom_range(1, 4), 0, 0);
    full_runs += 3;
  endtask

  // Random load-and-run sequences under one idling pattern; mostly short
  // lists, sometimes up to and past full, some empty, with noise beats and
  // the odd change of merge order between runs.
  task automatic test_random_merges(input int send_pct, input int recv_pct,
                                    input int item_goal);
    int phase_start;
    int first_len;
    int second_len;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    phase_start    = beats_sent;
    set_order_mode(1'($urandom_range(1)));
    while (beats_sent - phase_start < item_goal) begin
      first_len  = ($urandom_range(19) == 0) ? $urandom_range(LIST_DEPTH + 3)
                                             : $urandom_range(6);
      second_len = ($urandom_range(19) == 0) ? $urandom_range(LIST_DEPTH + 3)
                                             : $urandom_range(6);
      if (first_len >= LIST_DEPTH || second_len >= LIST_DEPTH) full_runs++;
      load_and_run(first_len, second_len, 8);
      if ($urandom_range(9) == 0) set_order_mode(1'($urandom_range(1)));
    end
  endtask

  initial begin
    // hold reset, then release it at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_full_lists();
    test_random_merges(0, 0, 62);
    test_random_merges(62, 0, 62);
    test_random_merges(0, 62, 62);
    test_random_merges(12, 12, 62);

    drain_block();
    $display("Sent %0d input beats in %0d runs (%0d reaching a full list)",
             beats_sent, runs_sent, full_runs);
    $display("Checked %0d merged beats in both orders, %0d mismatches",
             beats_merged, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/tlm_pkg.sv
sv/tlm_ctrl.sv
sv/tlm_dp.sv
sv/two_list_merge_core.sv
test/tb.sv
